// ----- design/plm_pkg.sv -----
package plm_pkg;

  // Default sample width; samples are signed Q16.16 at this width
  localparam int unsigned DATA_WIDTH = 32;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR_ENABLE = 2'd0,
    CFG_FLOOR_VALUE  = 2'd1
  } cfg_reg_e;

  // Window stage status handed to the top level
  typedef struct packed {
    logic valid;
    logic drain;
  } win_ctrl_t;

endpackage

// ----- design/plm_sample_if.sv -----
interface plm_sample_if #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] sample;
  logic                 row_start;

  modport source (output valid, output sample, output row_start, input ready);
  modport sink   (input valid, input sample, input row_start, output ready);
endinterface

// ----- design/plm_face_if.sv -----
interface plm_face_if #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] minus_face;
  logic signed [DW-1:0] plus_face;
  logic                 saturated;

  modport source (output valid, output minus_face, output plus_face, output saturated,
                  input ready);
  modport sink   (input valid, input minus_face, input plus_face, input saturated,
                  output ready);
endinterface

// ----- design/plm_cfg_if.sv -----
interface plm_cfg_if #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [plm_pkg::CFG_IDX_W-1:0]  index;
  logic [DW-1:0]                  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- design/plm_limited_face_reconstruction.sv -----
// Piecewise-linear face reconstruction with a monotonised-central limiter. Samples of one
// row stream in on in_sink (signed fixed point, Q16.16 at the default width); row_start
// empties the three-sample window. From the third sample of a row on, each item yields one
// result for the cell before it: lower and upper face values, clipped to range (flagged)
// and raised to floor_value when floor_enable is set. One item per cycle while the output
// is not stalled; a result is presented on out_src once its item has passed the window
// register and then the result register, with the limiter logic between the two.
// Write the registers only while idle.
module plm_limited_face_reconstruction #(
  parameter int unsigned DATA_WIDTH = plm_pkg::DATA_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  plm_sample_if.sink   in_sink,
  plm_face_if.source   out_src,
  plm_cfg_if.sink      cfg_sink
);

  plm_pkg::win_ctrl_t           win_ctrl;
  logic signed [DATA_WIDTH-1:0] win_l, win_c, win_r;
  logic                         floor_en;
  logic signed [DATA_WIDTH-1:0] floor_val;
  logic signed [DATA_WIDTH-1:0] lo_face, hi_face;
  logic                         sat;
  logic                         out_free, accept;

  logic                         out_valid_q, out_valid_d;
  logic signed [DATA_WIDTH-1:0] minus_q, plus_q;
  logic                         sat_q;

  assign out_free     = !out_valid_q || out_src.ready;
  assign in_sink.ready = !win_ctrl.valid || out_free;
  assign accept       = in_sink.valid && in_sink.ready;

  plm_cfg_regs #(.DW(DATA_WIDTH)) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg            (cfg_sink),
    .floor_enable_o (floor_en),
    .floor_value_o  (floor_val)
  );

  plm_window #(.DW(DATA_WIDTH)) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (in_sink.sample),
    .row_start_i (in_sink.row_start),
    .drain_i     (out_free),
    .ctrl_o      (win_ctrl),
    .left_o      (win_l),
    .centre_o    (win_c),
    .right_o     (win_r)
  );

  plm_limiter #(.DW(DATA_WIDTH)) u_lim (
    .left_i         (win_l),
    .centre_i       (win_c),
    .right_i        (win_r),
    .floor_enable_i (floor_en),
    .floor_value_i  (floor_val),
    .minus_face_o   (lo_face),
    .plus_face_o    (hi_face),
    .saturated_o    (sat)
  );

  assign out_valid_d = out_free ? win_ctrl.valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_ctrl.drain) begin
      minus_q <= lo_face;
      plus_q  <= hi_face;
      sat_q   <= sat;
    end
  end

  assign out_src.valid      = out_valid_q;
  assign out_src.minus_face = minus_q;
  assign out_src.plus_face  = plus_q;
  assign out_src.saturated  = sat_q;

endmodule

// ----- design/plm_cfg_regs.sv -----
module plm_cfg_regs #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  plm_cfg_if.sink              cfg,
  output logic                 floor_enable_o,
  output logic signed [DW-1:0] floor_value_o
);

  logic                 floor_enable_q;
  logic signed [DW-1:0] floor_value_q;
  logic                 wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_enable_q <= 1'b0;
      floor_value_q  <= '0;
    end else if (wr) begin
      unique case (plm_pkg::cfg_reg_e'(cfg.index))
        plm_pkg::CFG_FLOOR_ENABLE: floor_enable_q <= cfg.wdata[0];
        plm_pkg::CFG_FLOOR_VALUE:  floor_value_q  <= $signed(cfg.wdata);
        default: ;
      endcase
    end
  end

  assign floor_enable_o = floor_enable_q;
  assign floor_value_o  = floor_value_q;

endmodule

// ----- design/plm_window.sv -----
module plm_window #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic signed [DW-1:0] sample_i,
  input  logic                 row_start_i,
  input  logic                 drain_i,
  output plm_pkg::win_ctrl_t   ctrl_o,
  output logic signed [DW-1:0] left_o,
  output logic signed [DW-1:0] centre_o,
  output logic signed [DW-1:0] right_o
);

  logic [1:0]           fill_q, fill_d, fill_eff;
  logic signed [DW-1:0] older_q, newer_q;
  logic signed [DW-1:0] left_q, centre_q, right_q;
  logic                 full_q, full_d;
  logic                 emit;

  // row_start empties the window before the item is taken in
  assign fill_eff = row_start_i ? 2'd0 : fill_q;
  assign emit     = accept_i && (fill_eff == 2'd2);

  always_comb begin
    fill_d = fill_q;
    full_d = full_q;
    if (accept_i) begin
      fill_d = (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
      full_d = emit;
    end else if (drain_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      full_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      older_q <= newer_q;
      newer_q <= sample_i;
    end
    if (emit) begin
      left_q   <= older_q;
      centre_q <= newer_q;
      right_q  <= sample_i;
    end
  end

  assign ctrl_o.valid = full_q;
  assign ctrl_o.drain = drain_i && full_q;
  assign left_o       = left_q;
  assign centre_o     = centre_q;
  assign right_o      = right_q;

endmodule

// ----- design/plm_limiter.sv -----
module plm_limiter #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
) (
  input  logic signed [DW-1:0] left_i,
  input  logic signed [DW-1:0] centre_i,
  input  logic signed [DW-1:0] right_i,
  input  logic                 floor_enable_i,
  input  logic signed [DW-1:0] floor_value_i,
  output logic signed [DW-1:0] minus_face_o,
  output logic signed [DW-1:0] plus_face_o,
  output logic                 saturated_o
);

  localparam int unsigned EW = DW + 2;
  localparam logic signed [EW-1:0] MIN_X = {3'b111, {(DW-1){1'b0}}};
  localparam logic signed [EW-1:0] MAX_X = {3'b000, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};

  logic signed [EW-1:0] l_x, c_x, r_x, dl, dr, dlr, lo_w, hi_w;
  logic [DW-1:0]        dl_mag, dr_mag, dc_mag, min_lr, mag;
  logic                 mono, lo_sat, hi_sat;
  logic signed [DW-1:0] lo_v, hi_v;

  assign l_x = EW'(left_i);
  assign c_x = EW'(centre_i);
  assign r_x = EW'(right_i);

  assign dl  = c_x - l_x;
  assign dr  = r_x - c_x;
  assign dlr = r_x - l_x;

  // strictly monotone through the centre, otherwise flat
  assign mono = (dl > 0 && dr > 0) || (dl < 0 && dr < 0);

  assign dl_mag = dl[EW-1]  ? DW'(-dl)  : DW'(dl);
  assign dr_mag = dr[EW-1]  ? DW'(-dr)  : DW'(dr);
  assign dc_mag = dlr[EW-1] ? DW'((-dlr) >>> 2) : DW'(dlr >>> 2);

  assign min_lr = (dl_mag < dr_mag) ? dl_mag : dr_mag;
  assign mag    = !mono ? '0 : ((min_lr < dc_mag) ? min_lr : dc_mag);

  assign lo_w = c_x - $signed({2'b00, mag});
  assign hi_w = c_x + $signed({2'b00, mag});

  assign lo_sat = lo_w < MIN_X;
  assign hi_sat = hi_w > MAX_X;

  always_comb begin
    lo_v = lo_sat ? MIN_V : lo_w[DW-1:0];
    hi_v = hi_sat ? MAX_V : hi_w[DW-1:0];
    if (floor_enable_i) begin
      if (lo_v < floor_value_i) lo_v = floor_value_i;
      if (hi_v < floor_value_i) hi_v = floor_value_i;
    end
  end

  assign minus_face_o = lo_v;
  assign plus_face_o  = hi_v;
  assign saturated_o  = lo_sat || hi_sat;

endmodule

// ----- design/plm_checker.sv -----
module plm_checker #(
  parameter int unsigned DW = plm_pkg::DATA_WIDTH
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [DW-1:0] out_minus_i,
  input logic [DW-1:0] out_plus_i,
  input logic          out_sat_i,
  input logic          cfg_ready_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_minus_i)
      && $stable(out_plus_i) && $stable(out_sat_i))
    else $error("result changed while stalled");

  // input only back-pressures when the result register is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && !out_ready_i) |-> in_ready_i)
    else $error("input stalled with output free");

  // limited faces stay between neighbours, so no clipping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_sat_i)
    else $error("unexpected saturation");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("config port not ready");

endmodule

bind plm_limited_face_reconstruction plm_checker #(.DW(DATA_WIDTH)) u_plm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_sink.ready),
  .out_valid_i (out_src.valid),
  .out_ready_i (out_src.ready),
  .out_minus_i (out_src.minus_face),
  .out_plus_i  (out_src.plus_face),
  .out_sat_i   (out_src.saturated),
  .cfg_ready_i (cfg_sink.ready)
);

// ----- verif/plm_face_checker.sv -----
module plm_face_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  plm_sample_if       smp_mon,
  plm_face_if         face_mon,
  plm_cfg_if          cfg_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_WIDTH  = plm_pkg::DATA_WIDTH;
  localparam int unsigned XW          = DATA_WIDTH + 2;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct {
    logic signed [DATA_WIDTH-1:0] minus_face;
    logic signed [DATA_WIDTH-1:0] plus_face;
    logic                         saturated;
  } faces_t;

  logic signed [DATA_WIDTH-1:0] older_s;
  logic signed [DATA_WIDTH-1:0] newer_s;
  logic [1:0]                   fill;
  logic                         flr_en;
  logic signed [DATA_WIDTH-1:0] flr_val;
  faces_t                       faces_q[$];
  faces_t                       exp_f;
  int unsigned                  mismatches;

  assign mismatches_o = mismatches;
  assign pending_o    = faces_q.size();

  // Limited half-slope of the centre cell, then both faces clipped and floored
  function automatic faces_t limit_faces(input logic signed [DATA_WIDTH-1:0] left,
                                         input logic signed [DATA_WIDTH-1:0] centre,
                                         input logic signed [DATA_WIDTH-1:0] right,
                                         input logic                         en,
                                         input logic signed [DATA_WIDTH-1:0] flr);
    logic signed [XW-1:0] l_x, c_x, r_x, dl, dr, dc, lo, hi;
    logic [XW-1:0]        abs_l, abs_r, abs_c, mag;
    faces_t               f;
    l_x = left;
    c_x = centre;
    r_x = right;
    dl  = c_x - l_x;
    dr  = r_x - c_x;
    dc  = r_x - l_x;
    mag = '0;
    if ((dl > 0 && dr > 0) || (dl < 0 && dr < 0)) begin
      abs_l = (dl < 0) ? -dl : dl;
      abs_r = (dr < 0) ? -dr : dr;
      // quarter of the central difference, magnitude truncated
      abs_c = ((dc < 0) ? -dc : dc) >> 2;
      mag   = abs_l;
      if (abs_r < mag) mag = abs_r;
      if (abs_c < mag) mag = abs_c;
    end
    lo = c_x - $signed(mag);
    hi = c_x + $signed(mag);
    f.saturated = 1'b0;
    if (lo < Q_MIN) begin
      lo          = Q_MIN;
      f.saturated = 1'b1;
    end
    if (hi > Q_MAX) begin
      hi          = Q_MAX;
      f.saturated = 1'b1;
    end
    f.minus_face = lo[DATA_WIDTH-1:0];
    f.plus_face  = hi[DATA_WIDTH-1:0];
    if (en) begin
      if (f.minus_face < flr) f.minus_face = flr;
      if (f.plus_face < flr) f.plus_face = flr;
    end
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_s    = '0;
      newer_s    = '0;
      fill       = '0;
      flr_en     = 1'b0;
      flr_val    = '0;
      mismatches = 0;
      faces_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          plm_pkg::CFG_FLOOR_ENABLE: flr_en = cfg_mon.wdata[0];
          plm_pkg::CFG_FLOOR_VALUE:  flr_val = cfg_mon.wdata;
          default: ;
        endcase
      end

      if (smp_mon.valid && smp_mon.ready) begin
        if (smp_mon.row_start) fill = '0;
        if (fill == 2'd2) begin
          faces_q.push_back(limit_faces(older_s, newer_s, smp_mon.sample, flr_en, flr_val));
        end
        older_s = newer_s;
        newer_s = smp_mon.sample;
        if (fill != 2'd2) fill = fill + 2'd1;
      end

      if (face_mon.valid && face_mon.ready) begin
        if (faces_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with none expected: minus %0d plus %0d sat %0b", $realtime,
                     face_mon.minus_face, face_mon.plus_face, face_mon.saturated);
        end else begin
          exp_f = faces_q.pop_front();
          if (exp_f.minus_face !== face_mon.minus_face ||
              exp_f.plus_face !== face_mon.plus_face ||
              exp_f.saturated !== face_mon.saturated) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: face mismatch: expected minus %0d plus %0d sat %0b, ",
                        "got minus %0d plus %0d sat %0b"},
                       $realtime, exp_f.minus_face, exp_f.plus_face, exp_f.saturated,
                       face_mon.minus_face, face_mon.plus_face, face_mon.saturated);
          end
        end
      end
    end
  end

endmodule

// ----- verif/plm_limited_face_reconstruction_tb.sv -----
module plm_limited_face_reconstruction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_WIDTH    = plm_pkg::DATA_WIDTH;
  localparam int unsigned CFG_IDX_W     = plm_pkg::CFG_IDX_W;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEG_ITEMS     = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED =
    CFG_IDX_W'(plm_pkg::CFG_FLOOR_VALUE + 1);
  localparam logic signed [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {ROW_NOISE, ROW_RAMP, ROW_WALK, ROW_EDGE} row_shape_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned src_idle_pct  = 29;
  int unsigned sink_idle_pct = 61;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned stall_cycles;

  plm_sample_if smp_if ();
  plm_face_if   face_if ();
  plm_cfg_if    cfg_if ();

  plm_limited_face_reconstruction u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_sink  (smp_if),
    .out_src  (face_if),
    .cfg_sink (cfg_if)
  );

  plm_face_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smp_mon      (smp_if),
    .face_mon     (face_if),
    .cfg_mon      (cfg_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    face_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: cycles in a row without any item moving on any channel
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (smp_if.valid && smp_if.ready) || (face_if.valid && face_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_sample(input logic signed [DATA_WIDTH-1:0] value, input logic first);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid     <= 1'b1;
    smp_if.sample    <= value;
    smp_if.row_start <= first;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
  endtask

  // Hold the sender until every expected face pair is out, then let the pipe empty
  task automatic settle();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high so that back-to-back writes follow each other without a gap
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic set_floor(input logic en, input logic signed [DATA_WIDTH-1:0] value);
    cfg_write(plm_pkg::CFG_FLOOR_ENABLE, ($urandom() & ~32'd1) | {31'd0, en});
    cfg_write(plm_pkg::CFG_FLOOR_VALUE, value);
    for (int i = CFG_IDX_UNMAPPED; i < 2 ** CFG_IDX_W; i++)
      cfg_write(CFG_IDX_W'(i), $urandom());
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_row(input int unsigned len);
    row_shape_e                   shape;
    int unsigned                  pick;
    logic signed [DATA_WIDTH-1:0] value;
    logic signed [DATA_WIDTH-1:0] step;
    logic signed [DATA_WIDTH+1:0] wide;
    pick  = $urandom_range(99);
    shape = (pick < 20) ? ROW_NOISE : (pick < 65) ? ROW_RAMP : (pick < 85) ? ROW_WALK : ROW_EDGE;
    value = $signed($urandom()) >>> $urandom_range(0, 31);
    step  = $urandom() >> $urandom_range(1, 31);
    if ($urandom_range(1) == 0) step = -step;
    for (int i = 0; i < len; i++) begin
      case (shape)
        ROW_NOISE: value = $urandom();
        ROW_RAMP: begin
          // mostly monotone, with the odd reversal to break the run
          wide = value;
          if ($urandom_range(7) == 0)
            wide = wide - (step >>> $urandom_range(0, 3));
          else
            wide = wide + (step >>> $urandom_range(0, 3));
          if (wide > Q_MAX)
            value = Q_MAX;
          else if (wide < Q_MIN)
            value = Q_MIN;
          else
            value = wide[DATA_WIDTH-1:0];
        end
        ROW_WALK: value = value + DATA_WIDTH'($urandom_range(6)) - DATA_WIDTH'(3);
        default: begin
          case ($urandom_range(5))
            0: value = Q_MIN;
            1: value = Q_MAX;
            2: value = '0;
            3: value = '1;
            4: value = Q_MIN + 1;
            default: value = Q_MAX - 1;
          endcase
        end
      endcase
      push_sample(value, (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0));
    end
  endtask

  initial begin
    int unsigned                  sent;
    int unsigned                  len;
    logic                         en;
    logic signed [DATA_WIDTH-1:0] flr;

    rst_ni           <= 1'b0;
    smp_if.valid     <= 1'b0;
    smp_if.sample    <= '0;
    smp_if.row_start <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= plm_pkg::CFG_FLOOR_ENABLE;
    cfg_if.wdata     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale swings: peaks and troughs at the range ends
    push_sample(Q_MIN, 1'b1);
    push_sample('0, 1'b0);
    push_sample(Q_MAX, 1'b0);
    push_sample('0, 1'b0);
    push_sample(Q_MIN, 1'b0);
    // flat, one-sided zero difference, quarter truncated to nothing, then to one
    push_sample(0, 1'b1);
    push_sample(0, 1'b0);
    push_sample(0, 1'b0);
    push_sample(1, 1'b0);
    push_sample(3, 1'b0);
    push_sample(7, 1'b0);
    // falling run
    push_sample(100, 1'b1);
    push_sample(50, 1'b0);
    push_sample(-20, 1'b0);
    push_sample(-21, 1'b0);
    // rows too short to fill the window
    push_sample(5, 1'b1);
    push_sample(9, 1'b1);
    push_sample(8, 1'b0);

    settle();
    set_floor(1'b1, '0);
    push_sample(-8, 1'b1);
    push_sample(-4, 1'b0);
    push_sample(4, 1'b0);
    push_sample(8, 1'b0);

    settle();
    set_floor(1'b1, Q_MIN);
    push_sample(Q_MIN, 1'b1);
    push_sample(Q_MIN, 1'b0);
    push_sample(Q_MAX, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 29;
          sink_idle_pct = 61;
        end
        1: begin
          src_idle_pct  = 61;
          sink_idle_pct = 29;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        settle();
        case ((phase * SEGMENTS + seg) % 6)
          0: begin
            en  = 1'b0;
            flr = '0;
          end
          1: begin
            en  = 1'b1;
            flr = Q_MIN;
          end
          2: begin
            en  = 1'b1;
            flr = $signed($urandom()) >>> $urandom_range(0, 31);
          end
          3: begin
            en  = 1'b1;
            flr = '0;
          end
          4: begin
            en  = 1'b1;
            flr = Q_MAX;
          end
          default: begin
            en  = 1'b0;
            flr = $urandom();
          end
        endcase
        set_floor(en, flr);
        sent = 0;
        while (sent < SEG_ITEMS) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 40);
          send_row(len);
          sent += len;
        end
      end
    end

    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/plm_pkg.sv
design/plm_sample_if.sv
design/plm_face_if.sv
design/plm_cfg_if.sv
design/plm_cfg_regs.sv
design/plm_window.sv
design/plm_limiter.sv
design/plm_limited_face_reconstruction.sv
design/plm_checker.sv
verif/plm_face_checker.sv
verif/plm_limited_face_reconstruction_tb.sv
